[sv/lcbc_pkg.sv]
// ----------------------------------------------------------------------------
// lcbc_pkg
// Shared widths, operation codes, register indexes and the configuration
// struct of the LED color blink controller.
// ----------------------------------------------------------------------------
package lcbc_pkg;

   localparam int OP_WIDTH        = 2;
   localparam int NOW_WIDTH       = 32;
   localparam int COLOR_WIDTH     = 32;
   localparam int PERIOD_WIDTH    = 16;
   localparam int COUNT_WIDTH     = 17;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int US_PER_MS       = 1000;
   localparam int LIMIT_WIDTH     = PERIOD_WIDTH + 10;
   localparam int TIME_WIDTH_DEF  = 32;

   localparam logic [OP_WIDTH-1:0] OP_UPDATE = 2'd0;
   localparam logic [OP_WIDTH-1:0] OP_START  = 2'd1;
   localparam logic [OP_WIDTH-1:0] OP_STOP   = 2'd2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ON_COLOR   = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OFF_COLOR  = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ON_PERIOD  = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OFF_PERIOD = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REPEAT     = 3'd4;

   typedef struct packed {
      logic [COLOR_WIDTH-1:0]        on_color;
      logic [COLOR_WIDTH-1:0]        off_color;
      logic [PERIOD_WIDTH-1:0]       on_period_ms;
      logic [PERIOD_WIDTH-1:0]       off_period_ms;
      logic signed [COUNT_WIDTH-1:0] repeat_count;
   } cfg_type;

endpackage

[sv/lcbc_step.sv]
// ----------------------------------------------------------------------------
// lcbc_step
// Blink state registers and the combinational update for one operation.
// ----------------------------------------------------------------------------
module lcbc_step #(
   parameter int TIME_WIDTH = lcbc_pkg::TIME_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  lcbc_pkg::cfg_type                  cfg,
   input  logic                               step_en,
   input  logic [lcbc_pkg::OP_WIDTH-1:0]      op,
   input  logic [lcbc_pkg::NOW_WIDTH-1:0]     now_us,
   output logic                               emit_valid,
   output logic [lcbc_pkg::COLOR_WIDTH-1:0]   emit_color
);
   import lcbc_pkg::*;

   localparam int EXT_WIDTH = (TIME_WIDTH > NOW_WIDTH) ? TIME_WIDTH : NOW_WIDTH;
   localparam int CMP_WIDTH = (TIME_WIDTH > LIMIT_WIDTH) ? TIME_WIDTH : LIMIT_WIDTH;

   logic                          active_ff, active_in;
   logic                          lit_ff, lit_in;
   logic [TIME_WIDTH-1:0]         start_ff, start_in;
   logic signed [COUNT_WIDTH-1:0] flashes_ff, flashes_in;
   logic [COLOR_WIDTH-1:0]        last_ff, last_in;

   logic [EXT_WIDTH-1:0]    now_ext;
   logic [TIME_WIDTH-1:0]   now_t;
   logic [TIME_WIDTH-1:0]   elapsed;
   logic [PERIOD_WIDTH-1:0] period;
   logic [LIMIT_WIDTH-1:0]  limit;
   logic                    expired;
   logic                    want;
   logic [COLOR_WIDTH-1:0]  cand;

   assign now_ext = EXT_WIDTH'(now_us);
   assign now_t   = now_ext[TIME_WIDTH-1:0];
   assign elapsed = now_t - start_ff;
   assign period  = lit_ff ? cfg.on_period_ms : cfg.off_period_ms;
   assign limit   = LIMIT_WIDTH'(period) * LIMIT_WIDTH'(US_PER_MS);
   assign expired = CMP_WIDTH'(elapsed) > CMP_WIDTH'(limit);

   always_comb begin
      active_in  = active_ff;
      lit_in     = lit_ff;
      start_in   = start_ff;
      flashes_in = flashes_ff;
      want       = 1'b0;
      cand       = cfg.off_color;
      case (op)
         OP_START: begin
            flashes_in = cfg.repeat_count;
            lit_in     = 1'b0;
            start_in   = '0;
            active_in  = 1'b1;
         end
         OP_STOP: begin
            active_in = 1'b0;
         end
         OP_UPDATE: begin
            if (!active_ff) begin
               want = 1'b1;
            end else if (expired) begin
               start_in = now_t;
               want     = 1'b1;
               if (lit_ff) begin
                  lit_in = 1'b0;
                  if (flashes_ff == '0) begin
                     active_in = 1'b0;
                  end
               end else begin
                  lit_in = 1'b1;
                  cand   = cfg.on_color;
                  if (flashes_ff > 0) begin
                     flashes_in = flashes_ff - COUNT_WIDTH'(1);
                  end
               end
            end
         end
         default: begin
         end
      endcase
      emit_valid = want && (cand != last_ff);
      emit_color = cand;
      last_in    = emit_valid ? cand : last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         lit_ff     <= 1'b0;
         start_ff   <= '0;
         flashes_ff <= '0;
         last_ff    <= '0;
      end else if (step_en) begin
         active_ff  <= active_in;
         lit_ff     <= lit_in;
         start_ff   <= start_in;
         flashes_ff <= flashes_in;
         last_ff    <= last_in;
      end
   end

endmodule

[sv/led_color_blink_controller_core.sv]
// ----------------------------------------------------------------------------
// led_color_blink_controller_core
// LED blink generator with repeat count: steady or blinking GRBW color output.
// ----------------------------------------------------------------------------
// One operation is taken per clock cycle unless a pending color is held by
// rsp_stall. A request transfer lands in an input register; when it advances,
// the blink state is updated (one subtract of the phase start from the time
// input and one compare against period * 1000) and a changed color is loaded
// into the result register, from which the color word is offered. The result
// register frees the request side whenever the pending color is taken or none
// is pending. csr_ready is always high.
module led_color_blink_controller_core #(
   parameter int TIME_WIDTH = lcbc_pkg::TIME_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [lcbc_pkg::OP_WIDTH-1:0]          req_operation,
   input  logic [lcbc_pkg::NOW_WIDTH-1:0]         req_now_us,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [lcbc_pkg::COLOR_WIDTH-1:0]       rsp_color_word,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [lcbc_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [lcbc_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);
   import lcbc_pkg::*;

   cfg_type                cfg_ff;
   logic                   req_vld_ff;
   logic [OP_WIDTH-1:0]    req_op_ff;
   logic [NOW_WIDTH-1:0]   req_now_ff;
   logic                   rsp_vld_ff;
   logic [COLOR_WIDTH-1:0] rsp_color_ff;
   logic                   advance;
   logic                   accept;
   logic                   emit_valid;
   logic [COLOR_WIDTH-1:0] emit_color;

   assign csr_ready      = 1'b1;
   assign advance        = req_vld_ff && (!rsp_vld_ff || !rsp_stall);
   assign req_stall      = req_vld_ff && !advance;
   assign accept         = req_valid && !req_stall;
   assign rsp_valid      = rsp_vld_ff;
   assign rsp_color_word = rsp_color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ON_COLOR:   cfg_ff.on_color      <= csr_wdata[COLOR_WIDTH-1:0];
            CSR_OFF_COLOR:  cfg_ff.off_color     <= csr_wdata[COLOR_WIDTH-1:0];
            CSR_ON_PERIOD:  cfg_ff.on_period_ms  <= csr_wdata[PERIOD_WIDTH-1:0];
            CSR_OFF_PERIOD: cfg_ff.off_period_ms <= csr_wdata[PERIOD_WIDTH-1:0];
            CSR_REPEAT:     cfg_ff.repeat_count  <= signed'(csr_wdata[COUNT_WIDTH-1:0]);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
      end else if (accept) begin
         req_vld_ff <= 1'b1;
      end else if (advance) begin
         req_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_op_ff  <= req_operation;
         req_now_ff <= req_now_us;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance && emit_valid) begin
         rsp_vld_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit_valid) begin
         rsp_color_ff <= emit_color;
      end
   end

   lcbc_step #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_step (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .step_en    (advance),
      .op         (req_op_ff),
      .now_us     (req_now_ff),
      .emit_valid (emit_valid),
      .emit_color (emit_color)
   );

endmodule
